// ===== rtl/pcir_pkg.sv =====
`timescale 1ns / 1ps
// Package for the prime counter: widths, defaults and the sequencer state type.
// Used by every module of the block; depends on nothing.
package pcir_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int COUNT_BITS = 16;
  localparam int SMALLEST_PRIME = 2;
  localparam int FIRST_ODD_DIVISOR = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_DIV,
    S_TEST,
    S_DONE
  } state_t;

endpackage

// ===== rtl/pcir_mod.sv =====
`timescale 1ns / 1ps
// Serial remainder unit: restoring division, one dividend bit per cycle.
// Depends on pcir_pkg for the default width.
module pcir_mod #(
  parameter int VALUE_BITS = pcir_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] rem
);
  import pcir_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] dvd;
  logic [VALUE_BITS-1:0] dvs;
  logic [VALUE_BITS:0]   part;
  logic [CNT_W-1:0]      cnt;
  logic                  running;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  assign shifted = {part[VALUE_BITS-1:0], dvd[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign rem     = part[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (running) begin
      dvd <= {dvd[VALUE_BITS-2:0], 1'b0};
      // Keep the shifted partial remainder when the subtraction borrows.
      if (diff[VALUE_BITS]) begin
        part <= shifted;
      end else begin
        part <= diff;
      end
    end
  end

endmodule

// ===== rtl/prime_count_in_range_top.sv =====
`timescale 1ns / 1ps
// Top level of the prime counter: request sequencer, candidate and divisor registers.
// Depends on pcir_pkg and instantiates the serial remainder unit pcir_mod.
//
// Counts the primes in the closed interval from max(2, range_low) to range_high
// by trial division with odd divisors d while d*d <= n. A request is transferred
// when start is high and busy is low; busy then stays high until the one-cycle
// done strobe that carries prime_count, and the receiver must take the result in
// that cycle since it cannot stall. Busy covers each candidate in turn, every odd
// divisor tried on it in the shared remainder unit and the done strobe, so the
// request time is set by the width of the interval and the size of its values.
// An empty interval raises done in the cycle right after the transfer.
// The count saturates at the largest value of prime_count.
module prime_count_in_range_top #(
  parameter int VALUE_BITS = pcir_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [VALUE_BITS-1:0]            range_low,
  input  logic [VALUE_BITS-1:0]            range_high,
  output logic                             busy,
  output logic                             done,
  output logic [pcir_pkg::COUNT_BITS-1:0]  prime_count
);
  import pcir_pkg::*;

  localparam int SQ_W = VALUE_BITS + 3;

  state_t                state, state_next;
  logic [VALUE_BITS-1:0] n, n_next;
  logic [VALUE_BITS-1:0] hi, hi_next;
  logic [VALUE_BITS-1:0] d, d_next;
  logic [SQ_W-1:0]       sq, sq_next;
  logic [COUNT_BITS-1:0] count, count_next;

  logic                  mod_go;
  logic                  mod_done;
  logic [VALUE_BITS-1:0] mod_rem;
  logic [VALUE_BITS-1:0] lo_eff;
  logic                  cand_fin;
  logic                  cand_prime;
  logic [SQ_W-1:0]       n_wide;
  logic [SQ_W-1:0]       d_wide;

  assign lo_eff = (range_low < VALUE_BITS'(SMALLEST_PRIME)) ?
                  VALUE_BITS'(SMALLEST_PRIME) : range_low;
  assign n_wide = SQ_W'(n);
  assign d_wide = SQ_W'(d);
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign prime_count = count;

  pcir_mod #(.VALUE_BITS(VALUE_BITS)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (n),
    .divisor  (d),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    n     <= n_next;
    hi    <= hi_next;
    d     <= d_next;
    sq    <= sq_next;
    count <= count_next;
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    hi_next    = hi;
    d_next     = d;
    sq_next    = sq;
    count_next = count;
    mod_go     = 1'b0;
    cand_fin   = 1'b0;
    cand_prime = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          n_next     = lo_eff;
          hi_next    = range_high;
          d_next     = VALUE_BITS'(FIRST_ODD_DIVISOR);
          sq_next    = SQ_W'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
          count_next = '0;
          if (range_high < lo_eff) begin
            state_next = S_DONE;
          end else begin
            state_next = S_CAND;
          end
        end
      end
      S_CAND: begin
        // Two and three are prime; other even values are not.
        if (n < VALUE_BITS'(4)) begin
          cand_fin   = 1'b1;
          cand_prime = 1'b1;
        end else if (!n[0]) begin
          cand_fin = 1'b1;
        end else if (SQ_W'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR) > n_wide) begin
          cand_fin   = 1'b1;
          cand_prime = 1'b1;
        end else begin
          mod_go     = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            cand_fin = 1'b1;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_next     = d + VALUE_BITS'(2);
            sq_next    = sq + {d_wide[SQ_W-3:0], 2'b00} + SQ_W'(4);
            state_next = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (sq > n_wide) begin
          cand_fin   = 1'b1;
          cand_prime = 1'b1;
        end else begin
          mod_go     = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cand_fin) begin
      if (cand_prime && (count != {COUNT_BITS{1'b1}})) begin
        count_next = count + 1'b1;
      end
      // The divisor search of every candidate starts again at three.
      d_next  = VALUE_BITS'(FIRST_ODD_DIVISOR);
      sq_next = SQ_W'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
      if (n == hi) begin
        state_next = S_DONE;
      end else begin
        n_next     = n + 1'b1;
        state_next = S_CAND;
      end
    end
  end

endmodule

// ===== rtl/pcir_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the prime counter, with the bind that attaches it.
// Depends on pcir_pkg and on the ports of prime_count_in_range_top.
module pcir_chk #(
  parameter int VALUE_BITS = pcir_pkg::VALUE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic [VALUE_BITS-1:0]            range_low,
  input logic [VALUE_BITS-1:0]            range_high,
  input logic                             busy,
  input logic                             done,
  input logic [pcir_pkg::COUNT_BITS-1:0]  prime_count
);
  import pcir_pkg::*;

  // A result is only shown while a request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // The strobe lasts a single cycle and frees the block right after.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("done longer than one cycle or block still busy");

  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("request transfer did not raise busy");

  // An upper bound below two or below the lower bound gives an empty interval,
  // answered at once with zero.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy &&
    ((range_high < VALUE_BITS'(SMALLEST_PRIME)) || (range_high < range_low))
    |=> done && (prime_count == '0))
    else $error("empty interval not answered with zero");

endmodule

bind prime_count_in_range_top pcir_chk #(.VALUE_BITS(VALUE_BITS)) u_pcir_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .range_low   (range_low),
  .range_high  (range_high),
  .busy        (busy),
  .done        (done),
  .prime_count (prime_count)
);

// ===== sim/prime_count_in_range_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking test for prime_count_in_range_top: drives bound pairs, checks every count.
// Depends on pcir_pkg and the RTL of prime_count_in_range_top; reads nothing else.
module prime_count_in_range_top_test;
  import pcir_pkg::*;

  localparam int VBITS = VALUE_BITS_DEF;
  localparam int SETTLE_CYCLES = 50;
  localparam int DRAIN_CYCLES = 400000;
  localparam int EXP_DEPTH = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [VBITS-1:0] range_low = '0;
  logic [VBITS-1:0] range_high = '0;
  logic busy;
  logic done;
  logic [COUNT_BITS-1:0] prime_count;

  // Ring of expected counts, written on each request transfer, read on each result.
  logic [COUNT_BITS-1:0] expected_counts [EXP_DEPTH];
  int items_sent = 0;
  int counts_checked = 0;
  int empty_requests = 0;
  int mismatches = 0;
  int no_gap_left = 0;

  prime_count_in_range_top #(.VALUE_BITS(VBITS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .range_low(range_low),
    .range_high(range_high),
    .busy(busy),
    .done(done),
    .prime_count(prime_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Independent count: try every divisor from 2 while its square fits.
  function automatic logic [COUNT_BITS-1:0] count_primes_in(input logic [VBITS-1:0] lo,
                                                           input logic [VBITS-1:0] hi);
    int n;
    int d;
    int total;
    bit composite;
    total = 0;
    n = (lo < SMALLEST_PRIME) ? SMALLEST_PRIME : int'(lo);
    while (n <= int'(hi)) begin
      composite = 1'b0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          composite = 1'b1;
          break;
        end
      end
      if (!composite) total++;
      n++;
    end
    if (total > (1 << COUNT_BITS) - 1) total = (1 << COUNT_BITS) - 1;
    return total[COUNT_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns  MISMATCH: %s", $time, msg);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      no_gap_left = $urandom_range(4, 12);
      return 0;
    end
    if (r < 35) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // Start stays high across back-to-back requests, so it is lowered only for a real gap.
  task automatic send_request(input logic [VBITS-1:0] lo, input logic [VBITS-1:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    range_low <= lo;
    range_high <= hi;
    do @(posedge clk); while (busy !== 1'b0);
    expected_counts[items_sent % EXP_DEPTH] = count_primes_in(lo, hi);
    items_sent++;
    if (hi < lo || hi < SMALLEST_PRIME) empty_requests++;
  endtask

  // One random interval above base: either up to span + 1 values wide, or reversed so it is empty.
  task automatic send_random_interval(input int base, input int span);
    int hi;
    if (base > 0 && $urandom_range(0, 99) < 15) begin
      hi = $urandom_range(0, base - 1);
    end else begin
      hi = base + $urandom_range(0, span);
      if (hi > (1 << VBITS) - 1) hi = (1 << VBITS) - 1;
    end
    send_request(base[VBITS-1:0], hi[VBITS-1:0]);
  endtask

  always @(posedge clk) begin
    logic [COUNT_BITS-1:0] want;
    if (!rst && done === 1'b1) begin
      if (counts_checked >= items_sent) begin
        report_mismatch($sformatf("count %0d arrived with no request outstanding",
                                  prime_count));
      end else begin
        want = expected_counts[counts_checked % EXP_DEPTH];
        counts_checked++;
        if (prime_count !== want)
          report_mismatch($sformatf("prime_count got %0d, want %0d", prime_count, want));
      end
    end
  end

  task automatic test_directed_bounds();
    send_request(16'd0, 16'd0);
    send_request(16'd0, 16'd1);
    send_request(16'd1, 16'd1);
    send_request(16'd0, 16'd2);
    send_request(16'd2, 16'd2);
    send_request(16'd3, 16'd3);
    send_request(16'd4, 16'd4);
    send_request(16'd2, 16'd3);
    send_request(16'd9, 16'd9);
    send_request(16'd49, 16'd49);
    send_request(16'd0, 16'd10);
    send_request(16'd0, 16'd100);
    send_request(16'd0, 16'd1000);
    // Reversed bounds give an empty interval; the last pair holds a single value.
    send_request(16'd5, 16'd4);
    send_request(16'd1, 16'd0);
    send_request(16'hFFFF, 16'd0);
    send_request(16'hFFFF, 16'hFFFE);
    send_request(16'hFFFF, 16'hFFFF);
    // 65521 is the largest prime that fits in 16 bits.
    send_request(16'd65521, 16'd65521);
    send_request(16'd65520, 16'hFFFF);
    send_request(16'h8000, 16'h8010);
    send_request(16'h7FF0, 16'h7FFF);
  endtask

  task automatic test_low_ranges();
    int i;
    for (i = 0; i < 60; i++) send_random_interval($urandom_range(0, 4095), 64);
  endtask

  // Large bounds cost many divisors per candidate, so these intervals stay narrow.
  task automatic test_high_ranges();
    int i;
    for (i = 0; i < 60; i++) send_random_interval($urandom_range(0, (1 << VBITS) - 1), 15);
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    @(posedge clk);
    start <= 1'b0;
    while (items_sent > counts_checked && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (items_sent > counts_checked)
      report_mismatch($sformatf("%0d counts never arrived", items_sent - counts_checked));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bounds();
    test_low_ranges();
    test_high_ranges();
    finish_run();
    $display("Covered %0d requests (%0d with an empty interval), %0d counts checked.",
             items_sent, empty_requests, counts_checked);
    $display("Bounds spanned the full 16-bit range with random gaps between requests.");
    if (mismatches == 0) begin
      $display("prime_count_in_range_top_test: done, clean");
    end else begin
      $display("prime_count_in_range_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("Run did not finish in time, %0d counts still outstanding.",
             items_sent - counts_checked);
    $display("prime_count_in_range_top_test: done, errors");
    $finish;
  end

endmodule
